@@ hw/rtl/riff_wave_header_parser_top_defines.svh @@
// Assertion macros used by the checker file.
`ifndef RIFF_WAVE_HEADER_PARSER_TOP_DEFINES_SVH
`define RIFF_WAVE_HEADER_PARSER_TOP_DEFINES_SVH

// Same-cycle implication, masked while reset is asserted.
`define RWHP_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is asserted.
`define RWHP_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rwhp_pkg.sv @@
package rwhp_pkg;

    // descriptor status codes
    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_SHORT       = 4'd1;
    localparam logic [3:0] ST_NO_RIFF     = 4'd2;
    localparam logic [3:0] ST_NO_WAVE     = 4'd3;
    localparam logic [3:0] ST_NO_FMT      = 4'd4;
    localparam logic [3:0] ST_NO_DATA     = 4'd5;
    localparam logic [3:0] ST_FMT_SMALL   = 4'd6;
    localparam logic [3:0] ST_NOT_PCM     = 4'd7;
    localparam logic [3:0] ST_BAD_CHANS   = 4'd8;
    localparam logic [3:0] ST_BAD_BITS    = 4'd9;

    // chunk ids as they sit in the byte history (first byte in the top byte)
    localparam logic [31:0] ID_RIFF = 32'h5249_4646;
    localparam logic [31:0] ID_WAVE = 32'h5741_5645;
    localparam logic [31:0] ID_FMT  = 32'h666D_7420;
    localparam logic [31:0] ID_DATA = 32'h6461_7461;

    // kind of the chunk header being read
    localparam logic [1:0] HK_OTHER = 2'd0;
    localparam logic [1:0] HK_FMT   = 2'd1;
    localparam logic [1:0] HK_DATA  = 2'd2;

    localparam int unsigned RIFF_END_IDX = 3;   // last byte of "RIFF"
    localparam int unsigned WAVE_END_IDX = 11;  // last byte of "WAVE"
    localparam int unsigned FIRST_HEADER = 12;
    localparam int unsigned HEADER_LEN   = 8;
    localparam int unsigned MIN_FILE     = 44;
    localparam int unsigned FMT_NEED     = 16;
    localparam int unsigned MIN_DATA_POS = 20;  // earliest possible data body
    localparam logic [15:0] PCM_TAG      = 16'd1;

    localparam logic [2:0] HDR_ID_DONE   = 3'd3;
    localparam logic [2:0] HDR_SIZE_DONE = 3'd7;

endpackage

@@ hw/rtl/riff_wave_header_parser_top.sv @@
// Channel | Signals                                           | Direction
// --------+---------------------------------------------------+----------
// input   | in_valid, in_stall, file_byte, last_byte          | byte in
// result  | out_valid, out_stall, status, channel_count,      | descriptor out
//         | sample_rate, sample_bits, data_start, data_length |
//
// One byte request is taken every cycle while in_stall is low; the parse state
// updates in the same cycle. The descriptor passes through two registers after
// the last byte is taken (byte -> summary register -> result register).
// rst_n clears the parse state and both valid flags asynchronously.
// in_stall rises only while a summary waits behind a stalled result register.
module riff_wave_header_parser_top #(
    parameter int OFFSET_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  file_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  status,
    output logic [1:0]  channel_count,
    output logic [31:0] sample_rate,
    output logic [4:0]  sample_bits,
    output logic [31:0] data_start,
    output logic [31:0] data_length
);
    import rwhp_pkg::*;

    localparam int OB    = OFFSET_BITS;
    localparam int SUM_W = 34;   // body + size + pad never overflows this
    localparam logic [OB-1:0]    MAXOFF   = '1;
    localparam logic [SUM_W-1:0] MAXOFF_W = SUM_W'(MAXOFF);

    // ---------------------------------------------------------------
    // Handshake
    // ---------------------------------------------------------------
    logic in_acc;
    logic out_free;
    logic snap_adv;
    logic snap_valid_reg, snap_valid_next;
    logic out_valid_reg, out_valid_next;

    assign out_free = !out_valid_reg || !out_stall;
    assign snap_adv = snap_valid_reg && out_free;
    assign in_stall = snap_valid_reg && !out_free;
    assign in_acc   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    assign snap_valid_next = (in_acc && last_byte) || (snap_valid_reg && !snap_adv);
    assign out_valid_next  = snap_adv || (out_valid_reg && out_stall);

    // ---------------------------------------------------------------
    // Parse state
    // ---------------------------------------------------------------
    logic [OB-1:0] pos_reg, pos_upd;
    logic [31:0]   recent_reg, recent_upd;
    logic [OB-1:0] nho_reg, nho_upd;          // next chunk header offset
    logic [1:0]    magic_reg, magic_upd;      // bit0 RIFF, bit1 WAVE
    logic [1:0]    kind_reg, kind_upd;
    logic          fmt_found_reg, fmt_found_upd;
    logic [OB-1:0] fmt_start_reg, fmt_start_upd;
    logic [31:0]   fmt_chunk_len_reg, fmt_chunk_len_upd;
    logic [15:0]   tag_reg, tag_upd;
    logic [15:0]   chans_reg, chans_upd;
    logic [31:0]   rate_reg, rate_upd;
    logic [15:0]   bits_reg, bits_upd;
    logic          data_found_reg, data_found_upd;
    logic [OB-1:0] data_start_reg, data_start_upd;
    logic [31:0]   data_chunk_len_reg, data_chunk_len_upd;

    logic [OB-1:0]    idx;
    logic [OB-1:0]    hdr_diff;
    logic [OB-1:0]    fmt_diff;
    logic [OB-1:0]    body;
    logic [31:0]      chunk_size;
    logic [SUM_W-1:0] nxt_w;
    logic             in_hdr;
    logic             in_fmt;

    assign recent_upd = {recent_reg[23:0], file_byte};
    assign idx        = pos_reg;
    assign hdr_diff   = idx - nho_reg;
    assign fmt_diff   = idx - fmt_start_reg;
    assign body       = idx + OB'(1);
    assign chunk_size = {recent_upd[7:0], recent_upd[15:8],
                         recent_upd[23:16], recent_upd[31:24]};
    assign nxt_w      = SUM_W'(body) + SUM_W'(chunk_size) + SUM_W'(chunk_size[0]);
    assign in_hdr     = (idx >= nho_reg) && (hdr_diff < OB'(HEADER_LEN));
    assign in_fmt     = fmt_found_reg && (idx >= fmt_start_reg)
                        && (fmt_diff < OB'(FMT_NEED));

    always_comb
    begin
        pos_upd            = pos_reg;
        nho_upd            = nho_reg;
        magic_upd          = magic_reg;
        kind_upd           = kind_reg;
        fmt_found_upd      = fmt_found_reg;
        fmt_start_upd      = fmt_start_reg;
        fmt_chunk_len_upd  = fmt_chunk_len_reg;
        tag_upd            = tag_reg;
        chans_upd          = chans_reg;
        rate_upd           = rate_reg;
        bits_upd           = bits_reg;
        data_found_upd     = data_found_reg;
        data_start_upd     = data_start_reg;
        data_chunk_len_upd = data_chunk_len_reg;

        // bytes at the saturation point are neither counted nor examined
        if (idx != MAXOFF)
        begin
            pos_upd = body;

            if (idx == OB'(RIFF_END_IDX) && recent_upd == ID_RIFF)
            begin
                magic_upd[0] = 1'b1;
            end
            if (idx == OB'(WAVE_END_IDX) && recent_upd == ID_WAVE)
            begin
                magic_upd[1] = 1'b1;
            end

            if (in_hdr && hdr_diff[2:0] == HDR_ID_DONE)
            begin
                priority if (recent_upd == ID_FMT)
                begin
                    kind_upd = HK_FMT;
                end
                else if (recent_upd == ID_DATA)
                begin
                    kind_upd = HK_DATA;
                end
                else
                begin
                    kind_upd = HK_OTHER;
                end
            end
            else if (in_hdr && hdr_diff[2:0] == HDR_SIZE_DONE)
            begin
                if (kind_reg == HK_FMT && !fmt_found_reg)
                begin
                    fmt_found_upd     = 1'b1;
                    fmt_start_upd     = body;
                    fmt_chunk_len_upd = chunk_size;
                end
                else if (kind_reg == HK_DATA && !data_found_reg)
                begin
                    data_found_upd     = 1'b1;
                    data_start_upd     = body;
                    data_chunk_len_upd = chunk_size;
                end
                nho_upd  = (nxt_w > MAXOFF_W) ? MAXOFF : nxt_w[OB-1:0];
                kind_upd = HK_OTHER;
            end

            // a fmt body starts after the current byte, so the old flags serve here
            if (in_fmt)
            begin
                unique case (fmt_diff[3:0])
                    4'd0:    tag_upd[7:0]    = file_byte;
                    4'd1:    tag_upd[15:8]   = file_byte;
                    4'd2:    chans_upd[7:0]  = file_byte;
                    4'd3:    chans_upd[15:8] = file_byte;
                    4'd4:    rate_upd[7:0]   = file_byte;
                    4'd5:    rate_upd[15:8]  = file_byte;
                    4'd6:    rate_upd[23:16] = file_byte;
                    4'd7:    rate_upd[31:24] = file_byte;
                    4'd14:   bits_upd[7:0]   = file_byte;
                    4'd15:   bits_upd[15:8]  = file_byte;
                    default: ;
                endcase
            end
        end
    end

    // last byte: the updated state goes to the summary, the parser restarts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg            <= '0;
            recent_reg         <= '0;
            nho_reg            <= OB'(FIRST_HEADER);
            magic_reg          <= '0;
            kind_reg           <= HK_OTHER;
            fmt_found_reg      <= 1'b0;
            fmt_start_reg      <= '0;
            fmt_chunk_len_reg  <= '0;
            tag_reg            <= '0;
            chans_reg          <= '0;
            rate_reg           <= '0;
            bits_reg           <= '0;
            data_found_reg     <= 1'b0;
            data_start_reg     <= '0;
            data_chunk_len_reg <= '0;
        end
        else if (in_acc)
        begin
            if (last_byte)
            begin
                pos_reg            <= '0;
                recent_reg         <= '0;
                nho_reg            <= OB'(FIRST_HEADER);
                magic_reg          <= '0;
                kind_reg           <= HK_OTHER;
                fmt_found_reg      <= 1'b0;
                fmt_start_reg      <= '0;
                fmt_chunk_len_reg  <= '0;
                tag_reg            <= '0;
                chans_reg          <= '0;
                rate_reg           <= '0;
                bits_reg           <= '0;
                data_found_reg     <= 1'b0;
                data_start_reg     <= '0;
                data_chunk_len_reg <= '0;
            end
            else
            begin
                pos_reg            <= pos_upd;
                recent_reg         <= recent_upd;
                nho_reg            <= nho_upd;
                magic_reg          <= magic_upd;
                kind_reg           <= kind_upd;
                fmt_found_reg      <= fmt_found_upd;
                fmt_start_reg      <= fmt_start_upd;
                fmt_chunk_len_reg  <= fmt_chunk_len_upd;
                tag_reg            <= tag_upd;
                chans_reg          <= chans_upd;
                rate_reg           <= rate_upd;
                bits_reg           <= bits_upd;
                data_found_reg     <= data_found_upd;
                data_start_reg     <= data_start_upd;
                data_chunk_len_reg <= data_chunk_len_upd;
            end
        end
    end

    // ---------------------------------------------------------------
    // Summary register: the finished file's state
    // ---------------------------------------------------------------
    logic [OB-1:0] s_len_reg;
    logic [1:0]    s_magic_reg;
    logic          s_fmt_found_reg;
    logic [OB-1:0] s_fmt_start_reg;
    logic [31:0]   s_fmt_chunk_len_reg;
    logic [15:0]   s_tag_reg;
    logic [15:0]   s_chans_reg;
    logic [31:0]   s_rate_reg;
    logic [15:0]   s_bits_reg;
    logic          s_data_found_reg;
    logic [OB-1:0] s_data_start_reg;
    logic [31:0]   s_data_chunk_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && last_byte)
        begin
            s_len_reg            <= pos_upd;
            s_magic_reg          <= magic_upd;
            s_fmt_found_reg      <= fmt_found_upd;
            s_fmt_start_reg      <= fmt_start_upd;
            s_fmt_chunk_len_reg  <= fmt_chunk_len_upd;
            s_tag_reg            <= tag_upd;
            s_chans_reg          <= chans_upd;
            s_rate_reg           <= rate_upd;
            s_bits_reg           <= bits_upd;
            s_data_found_reg     <= data_found_upd;
            s_data_start_reg     <= data_start_upd;
            s_data_chunk_len_reg <= data_chunk_len_upd;
        end
    end

    // ---------------------------------------------------------------
    // Checks and descriptor
    // ---------------------------------------------------------------
    logic [3:0]  st_next;
    logic [OB:0] fmt_end;
    logic [31:0] avail;
    logic [31:0] dlen_clip;

    assign fmt_end   = {1'b0, s_fmt_start_reg} + (OB + 1)'(FMT_NEED);
    assign avail     = 32'(s_len_reg - s_data_start_reg);
    assign dlen_clip = (s_data_chunk_len_reg > avail) ? avail : s_data_chunk_len_reg;

    // first failing check wins
    always_comb
    begin
        priority if (s_len_reg < OB'(MIN_FILE))
        begin
            st_next = ST_SHORT;
        end
        else if (!s_magic_reg[0])
        begin
            st_next = ST_NO_RIFF;
        end
        else if (!s_magic_reg[1])
        begin
            st_next = ST_NO_WAVE;
        end
        else if (!s_fmt_found_reg)
        begin
            st_next = ST_NO_FMT;
        end
        else if (!s_data_found_reg)
        begin
            st_next = ST_NO_DATA;
        end
        else if (s_fmt_chunk_len_reg < 32'(FMT_NEED) || fmt_end > {1'b0, s_len_reg})
        begin
            st_next = ST_FMT_SMALL;
        end
        else if (s_tag_reg != PCM_TAG)
        begin
            st_next = ST_NOT_PCM;
        end
        else if (s_chans_reg < 16'd1 || s_chans_reg > 16'd2)
        begin
            st_next = ST_BAD_CHANS;
        end
        else if (s_bits_reg != 16'd8 && s_bits_reg != 16'd16)
        begin
            st_next = ST_BAD_BITS;
        end
        else
        begin
            st_next = ST_OK;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    logic [3:0]  status_reg;
    logic [1:0]  chans_out_reg;
    logic [31:0] rate_out_reg;
    logic [4:0]  bits_out_reg;
    logic [31:0] dstart_out_reg;
    logic [31:0] dlen_out_reg;
    logic        ok;

    assign ok = (st_next == ST_OK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_adv)
        begin
            status_reg     <= st_next;
            chans_out_reg  <= ok ? s_chans_reg[1:0] : 2'd0;
            rate_out_reg   <= ok ? s_rate_reg : 32'd0;
            bits_out_reg   <= ok ? s_bits_reg[4:0] : 5'd0;
            dstart_out_reg <= ok ? 32'(s_data_start_reg) : 32'd0;
            dlen_out_reg   <= ok ? dlen_clip : 32'd0;
        end
    end

    assign status        = status_reg;
    assign channel_count = chans_out_reg;
    assign sample_rate   = rate_out_reg;
    assign sample_bits   = bits_out_reg;
    assign data_start    = dstart_out_reg;
    assign data_length   = dlen_out_reg;

endmodule

@@ hw/rtl/rwhp_checker.sv @@
`include "riff_wave_header_parser_top_defines.svh"

module rwhp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [7:0]  file_byte,
    input logic        last_byte,
    input logic        out_valid,
    input logic        out_stall,
    input logic [3:0]  status,
    input logic [1:0]  channel_count,
    input logic [31:0] sample_rate,
    input logic [4:0]  sample_bits,
    input logic [31:0] data_start,
    input logic [31:0] data_length
);
    import rwhp_pkg::*;

    // a failed file carries an all-zero descriptor
    `RWHP_ASSERT_NOW(a_fail_zero, clk, rst_n, out_valid && status != ST_OK, channel_count == 2'd0 && sample_rate == 32'd0 && sample_bits == 5'd0 && data_start == 32'd0 && data_length == 32'd0, "failed descriptor has non-zero fields")

    // a good file has legal PCM fields and a data body past the first header
    `RWHP_ASSERT_NOW(a_ok_fields, clk, rst_n, out_valid && status == ST_OK, (channel_count == 2'd1 || channel_count == 2'd2) && (sample_bits == 5'd8 || sample_bits == 5'd16) && data_start >= 32'(MIN_DATA_POS), "good descriptor has illegal fields")

    // byte side only backs up behind a stalled result
    `RWHP_ASSERT_NOW(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without a held result")

    // held result stays valid and keeps its status and length
    `RWHP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(data_length), "stalled result changed")

endmodule

bind riff_wave_header_parser_top rwhp_checker u_rwhp_checker (.*);

@@ verif/wav_descriptor_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the header parser, rebuilds the expected descriptor
// for every file from the accepted byte requests and compares what comes out.
module wav_descriptor_checker #(
    parameter int OFFSET_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  file_byte,
    input  logic        last_byte,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  status,
    input  logic [1:0]  channel_count,
    input  logic [31:0] sample_rate,
    input  logic [4:0]  sample_bits,
    input  logic [31:0] data_start,
    input  logic [31:0] data_length,
    output int          errors,
    output int          pending,
    output int          checked,
    output logic [15:0] status_seen
);

    import rwhp_pkg::*;

    localparam longint unsigned MAX_OFFSET = (64'd1 << OFFSET_BITS) - 64'd1;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [3:0]  code;
        logic [1:0]  chans;
        logic [31:0] rate;
        logic [4:0]  bits;
        logic [31:0] start;
        logic [31:0] length;
    } descriptor_t;

    descriptor_t expected_descriptors[$];

    // parse state of the file in flight
    longint unsigned byte_idx;
    longint unsigned header_at;
    longint unsigned fmt_at;
    longint unsigned data_at;
    logic [31:0]     history;
    logic [31:0]     fmt_chunk_len;
    logic [31:0]     data_chunk_len;
    logic [31:0]     rate_seen;
    logic [15:0]     tag_seen;
    logic [15:0]     chans_seen;
    logic [15:0]     bits_seen;
    logic            riff_ok;
    logic            wave_ok;
    logic            fmt_ok;
    logic            data_ok;
    logic [1:0]      header_kind;

    task automatic clear_parse();
        byte_idx       = 0;
        header_at      = FIRST_HEADER;
        fmt_at         = 0;
        data_at        = 0;
        history        = '0;
        fmt_chunk_len  = '0;
        data_chunk_len = '0;
        rate_seen      = '0;
        tag_seen       = '0;
        chans_seen     = '0;
        bits_seen      = '0;
        riff_ok        = 1'b0;
        wave_ok        = 1'b0;
        fmt_ok         = 1'b0;
        data_ok        = 1'b0;
        header_kind    = HK_OTHER;
    endtask

    // One accepted byte request; on the last byte of a file, queue its descriptor.
    task automatic absorb_byte(input logic [7:0] b, input logic fin);
        longint unsigned idx;
        longint unsigned rel;
        longint unsigned body;
        longint unsigned nxt;
        longint unsigned len;
        longint unsigned room;
        logic [31:0]     sz;
        descriptor_t     want;
        idx     = byte_idx;
        history = {history[23:0], b};
        if (idx < MAX_OFFSET) begin
            if (idx == RIFF_END_IDX && history == ID_RIFF)
                riff_ok = 1'b1;
            if (idx == WAVE_END_IDX && history == ID_WAVE)
                wave_ok = 1'b1;
            if (idx >= header_at && idx - header_at < HEADER_LEN) begin
                rel = idx - header_at;
                if (rel == HDR_ID_DONE) begin
                    header_kind = (history == ID_FMT)  ? HK_FMT :
                                  (history == ID_DATA) ? HK_DATA : HK_OTHER;
                end else if (rel == HDR_SIZE_DONE) begin
                    sz   = {history[7:0], history[15:8], history[23:16], history[31:24]};
                    body = idx + 1;
                    nxt  = body + sz + sz[0];
                    if (header_kind == HK_FMT && !fmt_ok) begin
                        fmt_ok        = 1'b1;
                        fmt_at        = body;
                        fmt_chunk_len = sz;
                    end else if (header_kind == HK_DATA && !data_ok) begin
                        data_ok        = 1'b1;
                        data_at        = body;
                        data_chunk_len = sz;
                    end
                    header_at   = (nxt > MAX_OFFSET) ? MAX_OFFSET : nxt;
                    header_kind = HK_OTHER;
                end
            end
            if (fmt_ok && idx >= fmt_at && idx - fmt_at < FMT_NEED) begin
                case (idx - fmt_at)
                    0:  tag_seen[7:0]    = b;
                    1:  tag_seen[15:8]   = b;
                    2:  chans_seen[7:0]  = b;
                    3:  chans_seen[15:8] = b;
                    4:  rate_seen[7:0]   = b;
                    5:  rate_seen[15:8]  = b;
                    6:  rate_seen[23:16] = b;
                    7:  rate_seen[31:24] = b;
                    14: bits_seen[7:0]   = b;
                    15: bits_seen[15:8]  = b;
                    default: ;
                endcase
            end
            byte_idx = idx + 1;
        end
        if (fin) begin
            len  = byte_idx;
            want = '0;
            if (len < MIN_FILE)                        want.code = ST_SHORT;
            else if (!riff_ok)                         want.code = ST_NO_RIFF;
            else if (!wave_ok)                         want.code = ST_NO_WAVE;
            else if (!fmt_ok)                          want.code = ST_NO_FMT;
            else if (!data_ok)                         want.code = ST_NO_DATA;
            else if (fmt_chunk_len < FMT_NEED || fmt_at + FMT_NEED > len)
                                                       want.code = ST_FMT_SMALL;
            else if (tag_seen != PCM_TAG)              want.code = ST_NOT_PCM;
            else if (chans_seen < 1 || chans_seen > 2) want.code = ST_BAD_CHANS;
            else if (bits_seen != 8 && bits_seen != 16) want.code = ST_BAD_BITS;
            else                                       want.code = ST_OK;
            if (want.code == ST_OK) begin
                room        = len - data_at;
                want.chans  = chans_seen[1:0];
                want.rate   = rate_seen;
                want.bits   = bits_seen[4:0];
                want.start  = data_at[31:0];
                want.length = (data_chunk_len > room) ? room[31:0] : data_chunk_len;
            end
            expected_descriptors.push_back(want);
            clear_parse();
        end
    endtask

    task automatic check_descriptor();
        descriptor_t got;
        descriptor_t want;
        got.code   = status;
        got.chans  = channel_count;
        got.rate   = sample_rate;
        got.bits   = sample_bits;
        got.start  = data_start;
        got.length = data_length;
        if (expected_descriptors.size() == 0) begin
            if (errors < REPORT_LIMIT)
                $display("%0t: unexpected descriptor st=%0d ch=%0d rate=%0d bits=%0d start=%0d len=%0d",
                         $time, got.code, got.chans, got.rate, got.bits, got.start, got.length);
            errors++;
        end else begin
            want = expected_descriptors.pop_front();
            checked++;
            if (got.code !== want.code || got.chans !== want.chans || got.rate !== want.rate ||
                got.bits !== want.bits || got.start !== want.start ||
                got.length !== want.length) begin
                if (errors < REPORT_LIMIT) begin
                    $display("%0t: descriptor mismatch", $time);
                    $display("  expected st=%0d ch=%0d rate=%0d bits=%0d start=%0d len=%0d",
                             want.code, want.chans, want.rate, want.bits, want.start,
                             want.length);
                    $display("  actual   st=%0d ch=%0d rate=%0d bits=%0d start=%0d len=%0d",
                             got.code, got.chans, got.rate, got.bits, got.start, got.length);
                end
                errors++;
            end
        end
        if (got.code !== 4'bx)
            status_seen[got.code] = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            clear_parse();
            expected_descriptors.delete();
            errors      = 0;
            checked     = 0;
            status_seen = '0;
        end else begin
            if (in_valid && !in_stall)
                absorb_byte(file_byte, last_byte);
            if (out_valid && !out_stall)
                check_descriptor();
        end
        pending = expected_descriptors.size();
    end

endmodule

@@ verif/tb_riff_wave_header_parser_top.sv @@
`timescale 1ns / 100ps

// Streams WAV images, well-formed ones with random content and a share of broken
// ones and noise, into the header parser one byte request at a time. Both sides
// idle in short random bursts; the result side also holds off once for a long
// stretch so that the parser backs up. The checker does all prediction.
module tb_riff_wave_header_parser_top;

    import rwhp_pkg::*;

    localparam int CLK_HIGH     = 4;
    localparam int CLK_LOW      = 4;
    localparam int RESET_CYCLES = 8;
    localparam int HOLD_CYCLES  = 64;      // long result-side hold-off
    localparam int RANDOM_BYTES = 760;
    localparam int MIN_FILES    = 8;       // one descriptor per file
    localparam int DRAIN_CYCLES = 16;      // two-stage output path, with margin
    localparam int TIMEOUT_NS   = 2000000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  file_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [3:0]  status;
    logic [1:0]  channel_count;
    logic [31:0] sample_rate;
    logic [4:0]  sample_bits;
    logic [31:0] data_start;
    logic [31:0] data_length;

    int          errors;
    int          pending;
    int          checked;
    logic [15:0] status_seen;

    // Stimulus-side bookkeeping
    logic [7:0]  wav_bytes[$];
    int          gap_pct;          // idle chance per request, both sides
    logic        hold_go;
    bit          hold_done;
    bit          chunks_stopped;   // a huge chunk swallowed the rest of the file
    int          files_sent;
    int          bytes_sent;
    int          input_stalls;

    riff_wave_header_parser_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .file_byte     (file_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .channel_count (channel_count),
        .sample_rate   (sample_rate),
        .sample_bits   (sample_bits),
        .data_start    (data_start),
        .data_length   (data_length)
    );

    wav_descriptor_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .file_byte     (file_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .channel_count (channel_count),
        .sample_rate   (sample_rate),
        .sample_bits   (sample_bits),
        .data_start    (data_start),
        .data_length   (data_length),
        .errors        (errors),
        .pending       (pending),
        .checked       (checked),
        .status_seen   (status_seen)
    );

    always
    begin
        #CLK_LOW  clk = 1'b1;
        #CLK_HIGH clk = 1'b0;
    end

    // Hard stop in case the parser hangs or a handshake never completes.
    initial
    begin
        #TIMEOUT_NS;
        $display("Timed out with %0d descriptors outstanding", pending);
        $display("FAIL");
        $finish;
    end

    // ---------------------------------------------------------------------
    // File image builders. Chunk ids go out first byte first, i.e. top byte
    // of the package constant first; sizes and fields are little-endian.
    // ---------------------------------------------------------------------
    task automatic push_id(input logic [31:0] id);
        wav_bytes.push_back(id[31:24]);
        wav_bytes.push_back(id[23:16]);
        wav_bytes.push_back(id[15:8]);
        wav_bytes.push_back(id[7:0]);
    endtask

    task automatic push_le32(input logic [31:0] v);
        wav_bytes.push_back(v[7:0]);
        wav_bytes.push_back(v[15:8]);
        wav_bytes.push_back(v[23:16]);
        wav_bytes.push_back(v[31:24]);
    endtask

    task automatic push_noise(input int n);
        repeat (n) wav_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // fmt chunk: usually a proper 16-byte PCM body, sometimes extended, odd-sized
    // (pad byte) or cut below the 16 bytes the parser needs.
    task automatic add_fmt();
        logic [31:0]  sz;
        logic [15:0]  tag;
        logic [15:0]  chans;
        logic [15:0]  bits;
        logic [127:0] fields;
        int           pick;
        pick = $urandom_range(0, 19);
        if (pick < 12)      sz = FMT_NEED;
        else if (pick < 15) sz = 18;
        else if (pick < 17) sz = 17 + 2 * $urandom_range(0, 1);
        else                sz = $urandom_range(0, FMT_NEED - 1);

        tag = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 16'hFFFF)) : PCM_TAG;

        pick = $urandom_range(0, 9);
        if (pick < 7)       chans = 16'($urandom_range(1, 2));
        else if (pick == 7) chans = 16'd0;
        else if (pick == 8) chans = 16'd3;
        else                chans = 16'($urandom_range(0, 16'hFFFF));

        pick = $urandom_range(0, 9);
        if (pick < 7)       bits = ($urandom_range(0, 1) == 1) ? 16'd16 : 16'd8;
        else if (pick == 7) bits = 16'd24;
        else                bits = 16'($urandom_range(0, 16'hFFFF));

        // tag, channels, rate, byte rate, block align, bits - low byte first
        fields = {bits, 16'($urandom_range(0, 16'hFFFF)), 32'($urandom),
                  32'($urandom), chans, tag};

        push_id(ID_FMT);
        push_le32(sz);
        for (int k = 0; k < sz; k++)
        begin
            if (k < FMT_NEED) wav_bytes.push_back(fields[8*k +: 8]);
            else              push_noise(1);
        end
        if (sz[0]) push_noise(1);
    endtask

    // data chunk: small bodies sent whole, or now and then a size near the top
    // of the range so that the length gets clipped and the header walk saturates.
    task automatic add_data();
        logic [31:0] sz;
        if ($urandom_range(0, 9) == 0)
        begin
            sz = 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
            push_id(ID_DATA);
            push_le32(sz);
            push_noise($urandom_range(0, 12));
            chunks_stopped = 1'b1;
        end
        else
        begin
            sz = $urandom_range(0, 24);
            push_id(ID_DATA);
            push_le32(sz);
            push_noise(sz + sz[0]);
        end
    endtask

    // Unknown chunk, now and then with an id one bit away from fmt or data.
    task automatic add_other();
        logic [31:0] id;
        logic [31:0] sz;
        case ($urandom_range(0, 3))
            0:       id = ID_FMT ^ (32'd1 << $urandom_range(0, 31));
            1:       id = ID_DATA ^ (32'd1 << $urandom_range(0, 31));
            default: id = $urandom;
        endcase
        push_id(id);
        if ($urandom_range(0, 19) == 0)
        begin
            push_le32(32'hFFFF_FFFF);
            push_noise($urandom_range(0, 8));
            chunks_stopped = 1'b1;
        end
        else
        begin
            sz = $urandom_range(0, 12);
            push_le32(sz);
            push_noise(sz + sz[0]);
        end
    endtask

    task automatic build_file();
        int cut;
        wav_bytes.delete();
        chunks_stopped = 1'b0;
        if ($urandom_range(0, 9) == 0)
        begin
            // pure noise, mostly shorter than the smallest legal file
            push_noise($urandom_range(1, 60));
            return;
        end
        push_id(($urandom_range(0, 15) == 0) ? 32'($urandom) : ID_RIFF);
        push_le32($urandom);   // RIFF size, not checked by the parser
        push_id(($urandom_range(0, 15) == 0) ? 32'($urandom) : ID_WAVE);
        if ($urandom_range(0, 9) < 7)
        begin
            // the usual layout, with stray chunks around fmt and data
            if ($urandom_range(0, 3) == 0) add_other();
            if (!chunks_stopped) add_fmt();
            if (!chunks_stopped && $urandom_range(0, 3) == 0) add_other();
            if (!chunks_stopped) add_data();
            if (!chunks_stopped && $urandom_range(0, 3) == 0)
            begin
                // repeats must be ignored
                case ($urandom_range(0, 2))
                    0:       add_fmt();
                    1:       add_data();
                    default: add_other();
                endcase
            end
        end
        else
        begin
            // any order, any mix, fmt or data possibly missing
            repeat ($urandom_range(0, 4))
            begin
                if (!chunks_stopped)
                begin
                    case ($urandom_range(0, 2))
                        0:       add_fmt();
                        1:       add_data();
                        default: add_other();
                    endcase
                end
            end
        end
        if (!chunks_stopped && $urandom_range(0, 2) == 0)
            push_noise($urandom_range(1, 6));
        // cut short: short file, partial chunk header, fmt body ending early
        if ($urandom_range(0, 6) == 0 && wav_bytes.size() > 1)
        begin
            cut = $urandom_range(1, wav_bytes.size() - 1);
            while (wav_bytes.size() > cut) void'(wav_bytes.pop_back());
        end
    endtask

    // Offers the whole image, flagging the last byte. Valid may drop for a short
    // burst before any request but never because of in_stall.
    task automatic send_file();
        for (int i = 0; i < wav_bytes.size(); i++)
        begin
            if ($urandom_range(0, 99) < gap_pct)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            in_valid  <= 1'b1;
            file_byte <= wav_bytes[i];
            last_byte <= (i == wav_bytes.size() - 1);
            @(posedge clk);
            while (in_stall)
            begin
                input_stalls++;
                @(posedge clk);
            end
            bytes_sent++;
        end
        files_sent++;
    endtask

    // ---------------------------------------------------------------------
    // Result side: random stall bursts, plus the single long hold-off.
    // ---------------------------------------------------------------------
    initial
    begin
        out_stall <= 1'b0;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_go && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_done = 1'b1;
            end
            else if ($urandom_range(0, 99) < gap_pct)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        file_byte    <= 8'h00;
        last_byte    <= 1'b0;
        gap_pct      <= 0;
        hold_go      <= 1'b0;
        files_sent   = 0;
        bytes_sent   = 0;
        input_stalls = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: a one-byte file ends at once and reports a short file.
        wav_bytes.delete();
        wav_bytes.push_back(8'hFF);
        send_file();

        // Directed: smallest legal layout, stereo 16-bit at the top sample rate,
        // data size at its maximum so the length is clipped to what arrived.
        wav_bytes.delete();
        push_id(ID_RIFF);
        push_le32(32'd36);
        push_id(ID_WAVE);
        push_id(ID_FMT);
        push_le32(FMT_NEED);
        wav_bytes.push_back(PCM_TAG[7:0]);
        wav_bytes.push_back(PCM_TAG[15:8]);
        wav_bytes.push_back(8'd2);
        wav_bytes.push_back(8'd0);
        push_le32(32'hFFFF_FFFF);
        push_le32(32'h0000_0000);
        wav_bytes.push_back(8'd4);
        wav_bytes.push_back(8'd0);
        wav_bytes.push_back(8'd16);
        wav_bytes.push_back(8'd0);
        push_id(ID_DATA);
        push_le32(32'hFFFF_FFFF);
        wav_bytes.push_back(8'h00);
        wav_bytes.push_back(8'hFF);
        send_file();

        // Back-pressure: the result side holds off while a run of tiny files
        // keeps descriptors coming, so the parser has to stall its input.
        hold_go <= 1'b1;
        repeat (8)
        begin
            wav_bytes.delete();
            push_noise($urandom_range(1, 3));
            send_file();
        end

        // Random files, idling switched on or off per file.
        while (bytes_sent < RANDOM_BYTES || files_sent < MIN_FILES)
        begin
            gap_pct = ($urandom_range(0, 3) == 0) ? 0 : 30;
            build_file();
            send_file();
        end

        // Closing stretch at full rate on both sides.
        gap_pct = 0;
        repeat (4)
        begin
            build_file();
            send_file();
        end
        in_valid <= 1'b0;

        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d files in %0d byte requests; %0d descriptors checked,",
                 files_sent, bytes_sent, checked);
        $display("status codes seen %b, input held off for %0d cycles.",
                 status_seen, input_stalls);
        if (errors == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
